// ----- hdl/mcgp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the cloud group parser.
// Holds the parse phase enum, token state struct and result struct; no dependencies.
package mcgp_pkg;

    localparam int MAX_TOKEN_LEN = 9;
    localparam int CNT_W         = 4;
    localparam int HEIGHT_W      = 24;
    localparam int MIN_TOKEN_LEN = 3;

    typedef enum logic [5:0] {
        PH_START  = 6'b000001,
        PH_EXACT  = 6'b000010,
        PH_AFTER  = 6'b000100,
        PH_SLASH  = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_CLASS  = 6'b100000
    } t_phase;

    localparam logic [3:0] COV_UNKNOWN = 4'd0;
    localparam logic [3:0] COV_CLR     = 4'd1;
    localparam logic [3:0] COV_FEW     = 4'd2;
    localparam logic [3:0] COV_SCT     = 4'd3;
    localparam logic [3:0] COV_BKN     = 4'd4;
    localparam logic [3:0] COV_OVC     = 4'd5;
    localparam logic [3:0] COV_VV      = 4'd6;
    localparam logic [3:0] COV_NSC     = 4'd7;
    localparam logic [3:0] COV_NCD_SKC = 4'd8;

    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [CNT_W-1:0]    byte_count;
        t_phase              phase;
        logic [3:0]          coverage;
        logic [HEIGHT_W-1:0] height;
        logic                digits_seen;
        logic [2:0][7:0]     cls;
        logic [1:0]          cls_count;
        logic                err;
    } t_tok;

    localparam t_tok TOK_RESET = '{
        byte_count:  '0,
        phase:       PH_START,
        coverage:    COV_UNKNOWN,
        height:      '0,
        digits_seen: 1'b0,
        cls:         '0,
        cls_count:   2'd0,
        err:         1'b0
    };

    typedef struct packed {
        logic                valid_res;
        logic [3:0]          coverage;
        logic                height_present;
        logic [HEIGHT_W-1:0] height;
        logic [2:0][7:0]     cls;
        logic [1:0]          cls_length;
    } t_result;

endpackage

// ----- hdl/metar_cloud_group_parser.sv -----
`timescale 1ns / 1ps
// The result appears in the output register in the cycle after the last byte's beat.
// Throughput: one byte per cycle while no result waits to be taken; a new token may start right after a last byte.
// A result that waits to be taken stalls input beats while i_out_ready is low; with i_out_ready high they proceed.
// Reset (i_rst_n low, synchronous) clears token state and the output valid flag.
// Depends on mcgp_pkg and mcgp_next.
module metar_cloud_group_parser
    import mcgp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_char_in,
    input  logic                i_is_last,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_valid_res,
    output logic [3:0]          o_coverage,
    output logic                o_height_present,
    output logic [HEIGHT_W-1:0] o_height,
    output logic [7:0]          o_class_char0,
    output logic [7:0]          o_class_char1,
    output logic [7:0]          o_class_char2,
    output logic [1:0]          o_class_length
);

    t_tok       r_state;
    t_tok       n_state;
    logic [7:0] r_head0;
    logic [7:0] r_head1;
    t_result    r_out;
    t_result    n_out;
    logic       r_out_valid;
    logic       in_beat;
    logic       tok_ok;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_beat    = i_in_valid && o_in_ready;

    mcgp_next u_next (
        .i_state (r_state),
        .i_head0 (r_head0),
        .i_head1 (r_head1),
        .i_char  (i_char_in),
        .o_state (n_state)
    );

    assign tok_ok = !n_state.err && (n_state.byte_count >= CNT_W'(MIN_TOKEN_LEN))
                    && (n_state.phase != PH_START);

    always_comb begin
        n_out = '0;
        if (tok_ok) begin
            n_out.valid_res      = 1'b1;
            n_out.coverage       = n_state.coverage;
            n_out.height_present = n_state.digits_seen;
            n_out.height         = n_state.height;
            n_out.cls            = n_state.cls;
            n_out.cls_length     = n_state.cls_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= TOK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_state <= i_is_last ? TOK_RESET : n_state;
            end
            if (in_beat && i_is_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && !r_state.err && r_state.phase == PH_START) begin
            if (r_state.byte_count == CNT_W'(0)) begin
                r_head0 <= i_char_in;
            end
            if (r_state.byte_count == CNT_W'(1)) begin
                r_head1 <= i_char_in;
            end
        end
        if (in_beat && i_is_last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_valid_res      = r_out.valid_res;
    assign o_coverage       = r_out.coverage;
    assign o_height_present = r_out.height_present;
    assign o_height         = r_out.height;
    assign o_class_char0    = r_out.cls[0];
    assign o_class_char1    = r_out.cls[1];
    assign o_class_char2    = r_out.cls[2];
    assign o_class_length   = r_out.cls_length;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_is_last |=> o_out_valid)
        else $error("last beat did not load a result");

    a_mid_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && !i_is_last && !o_out_valid |=> !o_out_valid)
        else $error("result raised without a last beat");

    a_token_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_is_last |=> r_state.byte_count == '0 && !r_state.err
            && r_state.phase == PH_START)
        else $error("token state not cleared after last beat");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_valid_res |-> o_coverage == COV_UNKNOWN
            && o_height == '0 && o_class_length == 2'd0 && !o_height_present)
        else $error("invalid result carries nonzero fields");

    a_no_height_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_height_present |-> o_height == '0)
        else $error("height reported without digits");

endmodule

// ----- hdl/mcgp_next.sv -----
`timescale 1ns / 1ps
// Next token state for one byte of a cloud group.
// Combinational; uses mcgp_pkg types and constants.
module mcgp_next
    import mcgp_pkg::*;
(
    input  t_tok       i_state,
    input  logic [7:0] i_head0,
    input  logic [7:0] i_head1,
    input  logic [7:0] i_char,
    output t_tok       o_state
);

    function automatic t_tok add_class(input t_tok s, input logic [7:0] c);
        t_tok r;
        r = s;
        if (s.cls_count == 2'd3) begin
            r.err = 1'b1;
        end else begin
            r.cls[s.cls_count] = c;
            r.cls_count        = s.cls_count + 2'd1;
        end
        return r;
    endfunction

    logic                is_digit;
    logic                is_slash;
    logic [3:0]          dval;
    logic [23:0]         head3;
    logic [HEIGHT_W-1:0] height_x10;
    t_tok                n;

    assign is_digit   = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_slash   = (i_char == CH_SLASH);
    assign dval       = i_char[3:0];
    assign head3      = {i_head0, i_head1, i_char};
    assign height_x10 = (i_state.height << 3) + (i_state.height << 1);

    always_comb begin
        n = i_state;
        if (!i_state.err) begin
            if (i_state.byte_count >= CNT_W'(MAX_TOKEN_LEN)) begin
                n.err = 1'b1;
            end else begin
                n.byte_count = i_state.byte_count + CNT_W'(1);
                case (i_state.phase)
                    PH_START: begin
                        if (i_state.byte_count == CNT_W'(1) && i_head0 == CH_V
                            && i_char == CH_V) begin
                            n.coverage = COV_VV;
                            n.phase    = PH_AFTER;
                        end else if (i_state.byte_count == CNT_W'(2)) begin
                            if (head3 == "NSC") begin
                                n.coverage = COV_NSC;
                                n.phase    = PH_EXACT;
                            end else if (head3 == "NCD" || head3 == "SKC") begin
                                n.coverage = COV_NCD_SKC;
                                n.phase    = PH_EXACT;
                            end else if (head3 == "CLR") begin
                                n.coverage = COV_CLR;
                                n.phase    = PH_AFTER;
                            end else if (head3 == "FEW") begin
                                n.coverage = COV_FEW;
                                n.phase    = PH_AFTER;
                            end else if (head3 == "SCT") begin
                                n.coverage = COV_SCT;
                                n.phase    = PH_AFTER;
                            end else if (head3 == "BKN") begin
                                n.coverage = COV_BKN;
                                n.phase    = PH_AFTER;
                            end else if (head3 == "OVC") begin
                                n.coverage = COV_OVC;
                                n.phase    = PH_AFTER;
                            end else begin
                                n.err = 1'b1;
                            end
                        end
                    end
                    PH_EXACT: begin
                        n.err = 1'b1;
                    end
                    PH_AFTER: begin
                        if (is_digit) begin
                            n.height      = HEIGHT_W'(dval);
                            n.digits_seen = 1'b1;
                            n.phase       = PH_DIGITS;
                        end else begin
                            n       = add_class(n, i_char);
                            n.phase = is_slash ? PH_SLASH : PH_CLASS;
                        end
                    end
                    PH_SLASH: begin
                        if (is_slash && i_state.cls_count == 2'd2) begin
                            n.cls       = '0;
                            n.cls_count = 2'd0;
                            n.phase     = PH_CLASS;
                        end else begin
                            n = add_class(n, i_char);
                            if (!is_slash) begin
                                n.phase = PH_CLASS;
                            end
                        end
                    end
                    PH_DIGITS: begin
                        if (is_digit) begin
                            n.height = height_x10 + HEIGHT_W'(dval);
                        end else begin
                            n       = add_class(n, i_char);
                            n.phase = PH_CLASS;
                        end
                    end
                    PH_CLASS: begin
                        n = add_class(n, i_char);
                    end
                    default: begin
                        n.err = 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_state = n;

endmodule
